FILE: hw/rtl/csv_field_tokenizer_defines.svh
// Assertion macros shared by the tokenizer checker.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CSVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CSVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/csvt_pkg.sv
// Shared types, byte codes and helpers of the CSV field tokenizer.
// No dependencies.
`timescale 1ns / 1ps
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] BLK_SPACE = 2'd0;
  localparam logic [1:0] BLK_TAB   = 2'd1;
  localparam logic [1:0] BLK_LF    = 2'd2;

  // What an accepted word leads to.
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RESULT  = 2'd1,
    ACT_RELEASE = 2'd2
  } act_t;

  typedef struct packed {
    logic take;
    logic load_item;
    logic rd_en;
    logic load_blank;
    logic load_byte;
  } ctrl_cmd_t;

  typedef struct packed {
    act_t act;
    logic slot_free;
    logic rel_last;
  } dp_stat_t;

  function automatic logic [1:0] blank_code(input logic [7:0] b);
    logic [1:0] c;
    case (b)
      CH_SPACE: c = BLK_SPACE;
      CH_TAB:   c = BLK_TAB;
      default:  c = BLK_LF;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] blank_byte(input logic [1:0] c);
    logic [7:0] b;
    case (c)
      BLK_TAB: b = CH_TAB;
      BLK_LF:  b = CH_LF;
      default: b = CH_SPACE;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/csvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module csvt_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/csvt_ctrl.sv
// Sequencer of the tokenizer: accepts words and walks the held-blank release.
// Depends on csvt_pkg.
`timescale 1ns / 1ps
module csvt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csvt_pkg::dp_stat_t  stat,
  output csvt_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_BLANK = 4'b0100,
    S_BYTE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE) && stat.slot_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && stat.slot_free) begin
          cmd.take = 1'b1;
          if (stat.act == csvt_pkg::ACT_RESULT) begin
            cmd.load_item = 1'b1;
          end else if (stat.act == csvt_pkg::ACT_RELEASE) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_BLANK;
      end
      S_BLANK: begin
        if (stat.slot_free) begin
          cmd.load_blank = 1'b1;
          state_nxt      = stat.rel_last ? S_BYTE : S_READ;
        end
      end
      S_BYTE: begin
        if (stat.slot_free) begin
          cmd.load_byte = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/csvt_dp.sv
// Datapath of the tokenizer: parse state, blank store, output register.
// Depends on csvt_pkg and csvt_ram.
`timescale 1ns / 1ps
module csvt_dp #(
  parameter int MAX_COLUMNS = 256,
  parameter int BLANK_HOLD  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_text,
  input  csvt_pkg::ctrl_cmd_t cmd,
  output csvt_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_data_byte,
  output logic                out_byte_valid,
  output logic                out_end_of_field,
  output logic                out_end_of_row,
  output logic [7:0]          out_column_index,
  output logic                out_in_header,
  output logic                out_column_mismatch,
  output logic                out_blank_overflow,
  output logic                out_last
);

  localparam int FC_W  = $clog2(MAX_COLUMNS);
  localparam int HW_W  = $clog2(MAX_COLUMNS + 1);
  localparam int HC_W  = $clog2(BLANK_HOLD + 1);
  localparam int AW    = (BLANK_HOLD > 1) ? $clog2(BLANK_HOLD) : 1;
  localparam int EXT_W = (FC_W > 8) ? FC_W : 8;

  // parse state
  logic            quoting_r, quoting_nxt;
  logic            qcp_r, qcp_nxt;
  logic            cr_r, cr_nxt;
  logic            fhc_r, fhc_nxt;
  logic [HC_W-1:0] held_r, held_nxt;
  logic [FC_W-1:0] fc_r, fc_nxt;
  logic [HW_W-1:0] hw_r, hw_nxt;
  logic            hd_r, hd_nxt;
  logic            ro_r, ro_nxt;
  logic            ovf_r, ovf_nxt;

  // release bookkeeping
  logic [7:0]      rel_byte_r;
  logic            rel_ovf_r;
  logic [HC_W-1:0] rel_cnt_r;
  logic [HC_W-1:0] idx_r;

  // output register
  logic            ov_r;
  logic [7:0]      o_data_r;
  logic            o_bv_r, o_eof_r, o_eor_r, o_hdr_r, o_mism_r, o_ovf_r, o_last_r;
  logic [7:0]      o_col_r;

  // decode
  logic            go, q_eff, is_end, end_row, is_content, skip, wr_en, blank;
  logic [7:0]      bcur;
  logic            res_eof, res_eor, res_mism;
  logic [HW_W-1:0] count;
  logic [EXT_W-1:0] fc_ext;
  logic [7:0]      col;
  logic [1:0]      ram_q;
  csvt_pkg::act_t  act;

  assign count  = HW_W'(fc_r) + HW_W'(1);
  assign fc_ext = EXT_W'(fc_r);
  assign col    = (fc_ext > EXT_W'(255)) ? 8'hFF : fc_ext[7:0];
  assign blank  = bcur inside {csvt_pkg::CH_SPACE, csvt_pkg::CH_TAB, csvt_pkg::CH_LF};

  always_comb begin
    quoting_nxt = quoting_r;
    qcp_nxt     = qcp_r;
    cr_nxt      = cr_r;
    fhc_nxt     = fhc_r;
    held_nxt    = held_r;
    fc_nxt      = fc_r;
    hw_nxt      = hw_r;
    hd_nxt      = hd_r;
    ro_nxt      = ro_r;
    ovf_nxt     = ovf_r;
    wr_en       = 1'b0;
    act         = csvt_pkg::ACT_NONE;
    res_eof     = 1'b0;
    res_eor     = 1'b0;
    res_mism    = 1'b0;
    bcur        = in_byte;
    q_eff       = quoting_r;
    go          = 1'b1;
    is_end      = 1'b0;
    end_row     = 1'b0;
    is_content  = 1'b0;

    if (in_end_of_text) begin
      is_end  = ro_r;
      end_row = 1'b1;
    end else begin
      // a quote after a closing quote is a literal quote
      if (qcp_r) begin
        qcp_nxt = 1'b0;
        if (in_byte == csvt_pkg::CH_QUOTE) begin
          is_content = 1'b1;
          go         = 1'b0;
        end else begin
          q_eff       = 1'b0;
          quoting_nxt = 1'b0;
        end
      end
      // drop the LF of a CR LF pair
      if (go && cr_r) begin
        cr_nxt = 1'b0;
        if (in_byte == csvt_pkg::CH_LF) begin
          go = 1'b0;
        end
      end
      if (go) begin
        if (in_byte == csvt_pkg::CH_CR) begin
          cr_nxt = 1'b1;
          bcur   = csvt_pkg::CH_LF;
        end
        if (bcur == csvt_pkg::CH_QUOTE) begin
          ro_nxt = 1'b1;
          if (!q_eff) begin
            quoting_nxt = 1'b1;
          end else begin
            qcp_nxt = 1'b1;
          end
        end else if (!q_eff && (bcur == csvt_pkg::CH_COMMA || bcur == csvt_pkg::CH_LF)) begin
          is_end  = 1'b1;
          end_row = (bcur == csvt_pkg::CH_LF);
        end else begin
          is_content = 1'b1;
        end
      end
    end

    skip = end_row && hd_r && (fc_r == '0) && !fhc_r;

    if (is_end) begin
      fhc_nxt  = 1'b0;
      held_nxt = '0;
      ovf_nxt  = 1'b0;
      if (skip) begin
        ro_nxt = 1'b0;
      end else if (end_row) begin
        act      = csvt_pkg::ACT_RESULT;
        res_eof  = 1'b1;
        res_eor  = 1'b1;
        res_mism = hd_r && (count != hw_r);
        if (!hd_r) begin
          hw_nxt = count;
          hd_nxt = 1'b1;
        end
        fc_nxt = '0;
        ro_nxt = 1'b0;
      end else begin
        act     = csvt_pkg::ACT_RESULT;
        res_eof = 1'b1;
        ro_nxt  = 1'b1;
        if (fc_r < FC_W'(MAX_COLUMNS - 1)) begin
          fc_nxt = fc_r + FC_W'(1);
        end
      end
    end

    if (is_content) begin
      ro_nxt = 1'b1;
      if (blank) begin
        if (fhc_r) begin
          if (held_r < HC_W'(BLANK_HOLD)) begin
            wr_en    = 1'b1;
            held_nxt = held_r + HC_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end else begin
        act      = (held_r == '0) ? csvt_pkg::ACT_RESULT : csvt_pkg::ACT_RELEASE;
        held_nxt = '0;
        ovf_nxt  = 1'b0;
        fhc_nxt  = 1'b1;
      end
    end

    // end of text returns everything to the reset state
    if (in_end_of_text) begin
      quoting_nxt = 1'b0;
      qcp_nxt     = 1'b0;
      cr_nxt      = 1'b0;
      fhc_nxt     = 1'b0;
      held_nxt    = '0;
      fc_nxt      = '0;
      hw_nxt      = '0;
      hd_nxt      = 1'b0;
      ro_nxt      = 1'b0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quoting_r <= 1'b0;
      qcp_r     <= 1'b0;
      cr_r      <= 1'b0;
      fhc_r     <= 1'b0;
      held_r    <= '0;
      fc_r      <= '0;
      hw_r      <= '0;
      hd_r      <= 1'b0;
      ro_r      <= 1'b0;
      ovf_r     <= 1'b0;
      idx_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cmd.take) begin
        quoting_r <= quoting_nxt;
        qcp_r     <= qcp_nxt;
        cr_r      <= cr_nxt;
        fhc_r     <= fhc_nxt;
        held_r    <= held_nxt;
        fc_r      <= fc_nxt;
        hw_r      <= hw_nxt;
        hd_r      <= hd_nxt;
        ro_r      <= ro_nxt;
        ovf_r     <= ovf_nxt;
        idx_r     <= '0;
      end else if (cmd.load_blank) begin
        idx_r <= idx_r + HC_W'(1);
      end
      if (cmd.load_item || cmd.load_blank || cmd.load_byte) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rel_byte_r <= bcur;
      rel_ovf_r  <= ovf_r;
      rel_cnt_r  <= held_r;
    end
    if (cmd.load_item) begin
      o_data_r <= is_content ? bcur : 8'h00;
      o_bv_r   <= is_content;
      o_eof_r  <= res_eof;
      o_eor_r  <= res_eor;
      o_col_r  <= col;
      o_hdr_r  <= !hd_r;
      o_mism_r <= res_mism;
      o_ovf_r  <= is_content && ovf_r;
      o_last_r <= 1'b1;
    end else if (cmd.load_blank || cmd.load_byte) begin
      o_data_r <= cmd.load_blank ? csvt_pkg::blank_byte(ram_q) : rel_byte_r;
      o_bv_r   <= 1'b1;
      o_eof_r  <= 1'b0;
      o_eor_r  <= 1'b0;
      o_col_r  <= col;
      o_hdr_r  <= !hd_r;
      o_mism_r <= 1'b0;
      o_ovf_r  <= rel_ovf_r;
      o_last_r <= cmd.load_byte;
    end
  end

  csvt_ram #(
    .WIDTH (2),
    .DEPTH (BLANK_HOLD)
  ) u_blank_ram (
    .clk   (clk),
    .we    (cmd.take && wr_en),
    .waddr (held_r[AW-1:0]),
    .wdata (csvt_pkg::blank_code(bcur)),
    .re    (cmd.rd_en),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_q)
  );

  assign stat.act       = act;
  assign stat.slot_free = !ov_r || out_ready;
  assign stat.rel_last  = (idx_r == HC_W'(rel_cnt_r - HC_W'(1)));

  assign out_valid           = ov_r;
  assign out_data_byte       = o_data_r;
  assign out_byte_valid      = o_bv_r;
  assign out_end_of_field    = o_eof_r;
  assign out_end_of_row      = o_eor_r;
  assign out_column_index    = o_col_r;
  assign out_in_header       = o_hdr_r;
  assign out_column_mismatch = o_mism_r;
  assign out_blank_overflow  = o_ovf_r;
  assign out_last            = o_last_r;

endmodule

FILE: hw/rtl/csv_field_tokenizer.sv
// CSV field tokenizer: one raw byte a word in, field bytes and markers out,
// one field item a result word, with the held-blank release between them.
// Depends on csvt_pkg, csvt_ctrl and csvt_dp (which uses csvt_ram).
//
// Throughput: a word that leads to no result or to one result (a field or
// row marker, or a content byte with no blanks held in front of it) leaves
// the controller idle, so such words stream at one per clock while the output
// register is drained. A content byte that releases N held blanks (space, tab
// or LF kept inside a field until a later non-blank byte shows they are inner
// blanks) holds in_ready low after it is taken until its release is done:
// each blank is one registered read of the blank RAM followed by its load
// into the output register, then the byte itself; any output stall holds the
// release at the pending load. End of text flushes an open row as a row end
// and returns the tokenizer to its power-up state, expecting a new header row.
`timescale 1ns / 1ps
module csv_field_tokenizer #(
  parameter int MAX_COLUMNS = 256,  // column counter saturates at MAX_COLUMNS-1
  parameter int BLANK_HOLD  = 32    // depth of the trailing-blank store
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_field,
  output logic       out_end_of_row,
  output logic [7:0] out_column_index,
  output logic       out_in_header,
  output logic       out_column_mismatch,
  output logic       out_blank_overflow,
  output logic       out_last
);

  csvt_pkg::ctrl_cmd_t cmd;
  csvt_pkg::dp_stat_t  stat;

  // Controller: accept words, sequence the release of held blanks.
  csvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: quote/CR folding, field trimming, column counting, output register.
  csvt_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .BLANK_HOLD  (BLANK_HOLD)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_byte             (in_byte),
    .in_end_of_text      (in_end_of_text),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data_byte       (out_data_byte),
    .out_byte_valid      (out_byte_valid),
    .out_end_of_field    (out_end_of_field),
    .out_end_of_row      (out_end_of_row),
    .out_column_index    (out_column_index),
    .out_in_header       (out_in_header),
    .out_column_mismatch (out_column_mismatch),
    .out_blank_overflow  (out_blank_overflow),
    .out_last            (out_last)
  );

endmodule

FILE: hw/rtl/csvt_checker.sv
// Port-level checks of the tokenizer, bound to the top level.
// Depends on csv_field_tokenizer_defines.svh.
`timescale 1ns / 1ps
`include "csv_field_tokenizer_defines.svh"
module csvt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic       out_end_of_field,
  input logic       out_end_of_row,
  input logic       out_column_mismatch,
  input logic       out_last
);

  // a row end is always a field end that carries no byte
  `CSVT_ASSERT_NOW(a_row_is_field, out_valid && out_end_of_row, out_end_of_field && !out_byte_valid, "row end without field end")
  // a marker word never carries content
  `CSVT_ASSERT_NOW(a_marker_no_byte, out_valid && out_end_of_field, !out_byte_valid && out_last, "marker carries a byte or is not last")
  // mismatch is reported only on row ends
  `CSVT_ASSERT_NOW(a_mism_on_row, out_valid && out_column_mismatch, out_end_of_row, "mismatch outside row end")
  // a stalled result holds
  `CSVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data_byte) && $stable(out_last), "stalled result changed")

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for csv_field_tokenizer: a directed table, then random CSV text
// under several idle and stall mixes, each word checked against a table row or model.
// Depends on csvt_pkg and the csv_field_tokenizer RTL; reads no files.
module tb_top;

  localparam logic [7:0] CH_QUOTE = csvt_pkg::CH_QUOTE;
  localparam logic [7:0] CH_COMMA = csvt_pkg::CH_COMMA;
  localparam logic [7:0] CH_LF    = csvt_pkg::CH_LF;
  localparam logic [7:0] CH_CR    = csvt_pkg::CH_CR;
  localparam logic [7:0] CH_SPACE = csvt_pkg::CH_SPACE;
  localparam logic [7:0] CH_TAB   = csvt_pkg::CH_TAB;

  localparam int MAX_COLS        = 256;
  localparam int BLANK_DEPTH     = 32;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 80;     // well past the release of a full blank store
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_WORDS     = 80;
  localparam int SHOW_LIMIT      = 10;
  localparam int NUM_DIRECTED    = 25;

  // One result word as the block presents it.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       field_end;
    logic       row_end;
    logic [7:0] column;
    logic       header;
    logic       mismatch;
    logic       overflow;
    logic       last;
  } tok_word_t;

  // One row of the directed table. When typed is set, the expected word is the
  // one written in the row (or nothing, if yields is clear).
  typedef struct packed {
    logic [7:0] raw;
    logic       eot;
    logic       typed;
    logic       yields;
    tok_word_t  word;
  } stim_row_t;

  localparam tok_word_t NO_WORD = '0;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic       out_end_of_field;
  logic       out_end_of_row;
  logic [7:0] out_column_index;
  logic       out_in_header;
  logic       out_column_mismatch;
  logic       out_blank_overflow;
  logic       out_last;

  csv_field_tokenizer #(
    .MAX_COLUMNS(MAX_COLS),
    .BLANK_HOLD (BLANK_DEPTH)
  ) dut (.*);

  // ---------------------------------------------------------------------------
  // Bench-side tokenizer state
  // ---------------------------------------------------------------------------
  logic        quoting_q;
  logic        close_pend_q;     // quote seen inside quotes, next byte decides
  logic        cr_q;             // last byte was CR, swallow a following LF
  logic        has_text_q;       // field already holds a non-blank byte
  logic        row_open_q;
  logic        spill_q;          // blanks were dropped for lack of room
  logic        header_seen_q;
  logic [7:0]  held_q [BLANK_DEPTH];
  int unsigned held_n;
  int unsigned col_ctr;
  int unsigned header_cols;

  tok_word_t   step_words [$];     // words caused by the word being predicted
  tok_word_t   pending_tokens [$]; // words still owed by the block, oldest first

  int          mismatches = 0;
  int          words_sent = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          hold_asks  = 0;
  int          cycles     = 0;

  // Generator bookkeeping: what the random text believes the header looks like.
  int          table_cols  = 3;
  logic        need_header = 1'b1;

  stim_row_t   directed_rows [NUM_DIRECTED];

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic clear_field_state();
    has_text_q = 1'b0;
    held_n     = 0;
    spill_q    = 1'b0;
  endtask

  task automatic reset_tokenizer();
    quoting_q     = 1'b0;
    close_pend_q  = 1'b0;
    cr_q          = 1'b0;
    row_open_q    = 1'b0;
    header_seen_q = 1'b0;
    col_ctr       = 0;
    header_cols   = 0;
    clear_field_state();
  endtask

  task automatic emit(input logic [7:0] d, input logic has, input logic fe, input logic re,
                      input logic mm, input logic ov);
    tok_word_t w;
    w.data      = d;
    w.has_byte  = has;
    w.field_end = fe;
    w.row_end   = re;
    w.column    = (col_ctr > 255) ? 8'hFF : 8'(col_ctr);
    w.header    = !header_seen_q;
    w.mismatch  = mm;
    w.overflow  = ov;
    w.last      = 1'b0;
    step_words.insert(step_words.size(), w);
  endtask

  task automatic close_field(input logic at_row_end);
    if (at_row_end && header_seen_q && col_ctr == 0 && !has_text_q) begin
      // Skip a blank data row without a trace.
      clear_field_state();
      row_open_q = 1'b0;
    end else begin
      if (at_row_end) begin
        emit(8'h00, 1'b0, 1'b1, 1'b1, header_seen_q && (col_ctr + 1 != header_cols), 1'b0);
        if (!header_seen_q) begin
          header_cols   = col_ctr + 1;
          header_seen_q = 1'b1;
        end
        col_ctr    = 0;
        row_open_q = 1'b0;
      end else begin
        emit(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        row_open_q = 1'b1;
        if (col_ctr < MAX_COLS - 1) col_ctr++;
      end
      clear_field_state();
    end
  endtask

  task automatic field_char(input logic [7:0] b);
    logic spilled;
    int   i;
    row_open_q = 1'b1;
    if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
      // Drop leading blanks; hold inner ones until a non-blank shows up.
      if (has_text_q) begin
        if (held_n < BLANK_DEPTH) begin
          held_q[held_n] = b;
          held_n++;
        end else begin
          spill_q = 1'b1;
        end
      end
    end else begin
      spilled = spill_q;
      for (i = 0; i < held_n; i++) emit(held_q[i], 1'b1, 1'b0, 1'b0, 1'b0, spilled);
      emit(b, 1'b1, 1'b0, 1'b0, 1'b0, spilled);
      held_n     = 0;
      spill_q    = 1'b0;
      has_text_q = 1'b1;
    end
  endtask

  task automatic scan_byte(input logic [7:0] raw);
    logic [7:0] b;
    logic       done;
    b    = raw;
    done = 1'b0;
    if (close_pend_q) begin
      close_pend_q = 1'b0;
      if (b == CH_QUOTE) begin
        field_char(b);
        done = 1'b1;
      end else begin
        quoting_q = 1'b0;
      end
    end
    if (!done && cr_q) begin
      cr_q = 1'b0;
      if (b == CH_LF) done = 1'b1;
    end
    if (!done) begin
      if (b == CH_CR) begin
        cr_q = 1'b1;
        b    = CH_LF;
      end
      if (b == CH_QUOTE) begin
        row_open_q = 1'b1;
        if (!quoting_q) quoting_q = 1'b1;
        else close_pend_q = 1'b1;
      end else if (!quoting_q && (b == CH_COMMA || b == CH_LF)) begin
        close_field(b == CH_LF);
      end else begin
        field_char(b);
      end
    end
  endtask

  // Work out the words one input word causes, into step_words.
  task automatic tokenize_byte(input logic [7:0] raw, input logic eot);
    step_words.delete();
    if (eot) begin
      quoting_q    = 1'b0;
      close_pend_q = 1'b0;
      if (row_open_q) close_field(1'b1);
      reset_tokenizer();
    end else begin
      scan_byte(raw);
    end
    if (step_words.size() != 0) step_words[step_words.size() - 1].last = 1'b1;
  endtask

  task automatic owe_step_words();
    foreach (step_words[i]) pending_tokens.insert(pending_tokens.size(), step_words[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic string show_word(input tok_word_t w);
    return $sformatf("data=%h byte=%b eof=%b eor=%b col=%0d hdr=%b mism=%b ovf=%b last=%b",
                     w.data, w.has_byte, w.field_end, w.row_end, w.column, w.header,
                     w.mismatch, w.overflow, w.last);
  endfunction

  task automatic log_mismatch(input string why, input tok_word_t want, input tok_word_t got);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display("mismatch %0d (%s): expected %s | got %s", mismatches, why,
               show_word(want), show_word(got));
  endtask

  // Take each accepted result word and hold it against the oldest one owed.
  always @(posedge clk) begin
    tok_word_t got;
    if (rst_n && out_valid && out_ready) begin
      got.data      = out_data_byte;
      got.has_byte  = out_byte_valid;
      got.field_end = out_end_of_field;
      got.row_end   = out_end_of_row;
      got.column    = out_column_index;
      got.header    = out_in_header;
      got.mismatch  = out_column_mismatch;
      got.overflow  = out_blank_overflow;
      got.last      = out_last;
      if (pending_tokens.size() == 0) begin
        log_mismatch("nothing expected", NO_WORD, got);
      end else begin
        if (got !== pending_tokens[0]) log_mismatch("wrong word", pending_tokens[0], got);
        void'(pending_tokens.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clock, watchdog, receiver
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL csv_field_tokenizer");
      $finish;
    end
  end

  // Drive out_ready: random stalls, plus a long hold-off whenever one is asked for.
  // The hold-off is counted here so the sender keeps offering words meanwhile.
  initial begin
    int hold_left;
    int asks_seen;
    hold_left = 0;
    asks_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != asks_seen) begin
        asks_seen = hold_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Present one word and hold it until accepted. Call right after a rising edge.
  task automatic offer_word(input logic [7:0] b, input logic eot);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eot);
    tokenize_byte(b, eot);
    owe_step_words();
    offer_word(b, eot);
  endtask

  // Drop valid and wait until the block owes nothing.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random CSV text
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'hFF, 8'h21));
    while (c == CH_QUOTE || c == CH_COMMA) c = 8'($urandom_range(8'hFF, 8'h21));
    return c;
  endfunction

  // LF only counts as a blank inside quotes; outside it would end the row.
  function automatic logic [7:0] pick_blank(input logic quoted);
    case ($urandom_range(quoted ? 2 : 1))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  task automatic gen_row_end();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) begin
      send_byte(CH_LF, 1'b0);
    end else if (pick < 8) begin
      send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b0);
    end else begin
      send_byte(CH_CR, 1'b0);
    end
  endtask

  task automatic gen_field();
    int k;
    int len;
    int pick;
    repeat ($urandom_range(2)) send_byte(pick_blank(1'b0), 1'b0);
    pick = $urandom_range(99);
    len  = $urandom_range(5);
    if (pick < 6) begin
      // Long inner run: straddle the blank store depth so some runs overflow.
      send_byte(text_char(), 1'b0);
      repeat ($urandom_range(BLANK_DEPTH + 8, BLANK_DEPTH - 3)) send_byte(pick_blank(1'b0), 1'b0);
      send_byte(text_char(), 1'b0);
    end else if (pick < 36) begin
      send_byte(CH_QUOTE, 1'b0);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(9))
          0: begin
            send_byte(CH_QUOTE, 1'b0);
            send_byte(CH_QUOTE, 1'b0);
          end
          1:       send_byte(CH_COMMA, 1'b0);
          2:       send_byte(CH_CR, 1'b0);
          3:       send_byte(CH_LF, 1'b0);
          4:       send_byte(pick_blank(1'b1), 1'b0);
          default: send_byte(text_char(), 1'b0);
        endcase
      end
      send_byte(CH_QUOTE, 1'b0);
    end else begin
      for (k = 0; k < len; k++) begin
        if (k > 0 && $urandom_range(4) == 0)
          repeat ($urandom_range(3, 1)) send_byte(pick_blank(1'b0), 1'b0);
        send_byte(text_char(), 1'b0);
      end
    end
    repeat ($urandom_range(2)) send_byte(pick_blank(1'b0), 1'b0);
  endtask

  task automatic gen_row(input int ncols);
    int k;
    for (k = 0; k < ncols; k++) begin
      gen_field();
      if (k < ncols - 1) send_byte(CH_COMMA, 1'b0);
    end
    gen_row_end();
  endtask

  // Mostly well-formed rows; the rest blank rows, end of text and raw noise.
  task automatic gen_piece();
    int pick;
    int ncols;
    pick = $urandom_range(99);
    if (pick < 72) begin
      if (need_header) begin
        table_cols  = $urandom_range(6, 1);
        ncols       = table_cols;
        need_header = 1'b0;
      end else begin
        ncols = ($urandom_range(99) < 85) ? table_cols : $urandom_range(8, 1);
      end
      gen_row(ncols);
    end else if (pick < 80) begin
      repeat ($urandom_range(2)) send_byte(pick_blank(1'b0), 1'b0);
      gen_row_end();
    end else if (pick < 88) begin
      send_byte(8'($urandom_range(255)), 1'b1);
      need_header = 1'b1;
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  function automatic tok_word_t typed_word(input logic [7:0] d, input logic has,
                                           input logic fe, input logic re,
                                           input logic [7:0] col, input logic hdr,
                                           input logic mm, input logic ov);
    return '{d, has, fe, re, col, hdr, mm, ov, 1'b1};
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    int ph;
    int budget;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_byte        <= 8'h00;
    in_end_of_text <= 1'b0;
    reset_tokenizer();

    // Directed table: header "a,<00><FF> \tb\",\"\"\"" CRLF, a blank row, a short
    // data row, end of text in and out of a row, a blank header, an open quote at end.
    directed_rows = '{
      '{8'h61,    1'b0, 1'b1, 1'b1,
        typed_word(8'h61, 1'b1, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0)},
      '{CH_COMMA, 1'b0, 1'b1, 1'b1,
        typed_word(8'h00, 1'b0, 1'b1, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0)},
      '{8'h00,    1'b0, 1'b1, 1'b1,
        typed_word(8'h00, 1'b1, 1'b0, 1'b0, 8'd1, 1'b1, 1'b0, 1'b0)},
      '{8'hFF,    1'b0, 1'b1, 1'b1,
        typed_word(8'hFF, 1'b1, 1'b0, 1'b0, 8'd1, 1'b1, 1'b0, 1'b0)},
      '{CH_SPACE, 1'b0, 1'b1, 1'b0, NO_WORD},  // held behind text
      '{CH_TAB,   1'b0, 1'b1, 1'b0, NO_WORD},
      '{8'h62,    1'b0, 1'b0, 1'b0, NO_WORD},  // releases the two held blanks
      '{CH_QUOTE, 1'b0, 1'b1, 1'b0, NO_WORD},
      '{CH_COMMA, 1'b0, 1'b0, 1'b0, NO_WORD},  // comma inside quotes is text
      '{CH_QUOTE, 1'b0, 1'b1, 1'b0, NO_WORD},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, NO_WORD},  // doubled quote is a literal quote
      '{CH_QUOTE, 1'b0, 1'b1, 1'b0, NO_WORD},
      '{CH_CR,    1'b0, 1'b0, 1'b0, NO_WORD},  // closes the quote and the header row
      '{CH_LF,    1'b0, 1'b1, 1'b0, NO_WORD},  // LF of CRLF is swallowed
      '{CH_LF,    1'b0, 1'b1, 1'b0, NO_WORD},  // blank data row is skipped
      '{8'h78,    1'b0, 1'b0, 1'b0, NO_WORD},
      '{CH_LF,    1'b0, 1'b1, 1'b1,
        typed_word(8'h00, 1'b0, 1'b1, 1'b1, 8'd0, 1'b0, 1'b1, 1'b0)},
      '{8'h79,    1'b0, 1'b0, 1'b0, NO_WORD},
      '{8'hA5,    1'b1, 1'b0, 1'b0, NO_WORD},  // end of text flushes the open row
      '{8'h5A,    1'b1, 1'b1, 1'b0, NO_WORD},  // nothing open, nothing out
      '{CH_LF,    1'b0, 1'b1, 1'b1,
        typed_word(8'h00, 1'b0, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0)},
      '{CH_SPACE, 1'b0, 1'b1, 1'b0, NO_WORD},  // leading blank is dropped
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, NO_WORD},
      '{8'h71,    1'b0, 1'b0, 1'b0, NO_WORD},
      '{8'hC3,    1'b1, 1'b0, 1'b0, NO_WORD}   // end of text inside an open quote
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the table; advance the model on typed rows too so its state stays in step.
    for (i = 0; i < NUM_DIRECTED; i++) begin
      tokenize_byte(directed_rows[i].raw, directed_rows[i].eot);
      if (!directed_rows[i].typed) owe_step_words();
      else if (directed_rows[i].yields)
        pending_tokens.insert(pending_tokens.size(), directed_rows[i].word);
      offer_word(directed_rows[i].raw, directed_rows[i].eot);
    end
    drain();

    // Random text under four idle and stall mixes; drain between them so the
    // sender pauses with nothing owed at least once per phase.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 61; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      // With the sender running flat out, a long hold-off fills the block up
      // and forces it to stall its input.
      if (ph == 0) hold_asks++;
      budget = words_sent + PHASE_WORDS;
      while (words_sent < budget) gen_piece();
      drain();
    end

    // Let any stray words show up before deciding.
    idle_pct  = 0;
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_tokens.size() != 0) log_mismatch("never produced", pending_tokens[0], NO_WORD);

    if (mismatches == 0) $display("PASS csv_field_tokenizer");
    else $display("FAIL csv_field_tokenizer");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/csvt_pkg.sv
hw/rtl/csvt_ram.sv
hw/rtl/csvt_ctrl.sv
hw/rtl/csvt_dp.sv
hw/rtl/csv_field_tokenizer.sv
hw/rtl/csvt_checker.sv
bench/tb_top.sv
